>>> design/mme_pkg.sv
package mme_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int CFG_W       = 5;
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;

    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    // Input commands.
    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_M_ROWS  = 2'd0;
    localparam logic [1:0] REG_N_INNER = 2'd1;
    localparam logic [1:0] REG_O_COLS  = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

>>> design/mme_ram.sv
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/mme_mac.sv
module mme_mac
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    clk,
    input  mac_ctrl_t               ctrl,
    input  logic signed [VAL_W-1:0] a_data,
    input  logic signed [VAL_W-1:0] b_data,
    output logic signed [VAL_W-1:0] sum_value,
    output logic                    sum_sat
);

    localparam int PROD_W = 2 * VAL_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int ACC_W  = TERM_W + $clog2(MAX_DIM);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [TERM_W-1:0]        term;
    logic [ACC_W-VAL_W:0]     acc_hi;

    // Dropping the low fraction bits of a two's complement product rounds
    // toward minus infinity.
    assign term = prod_reg[PROD_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a_data * b_data;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + $signed({{(ACC_W-TERM_W){term[TERM_W-1]}}, term});
        end
    end

    // The sum fits in 32 bits when every bit from bit 31 upward agrees.
    assign acc_hi = acc_reg[ACC_W-1:VAL_W-1];

    always_comb
    begin
        if ((&acc_hi) || !(|acc_hi))
        begin
            sum_value = acc_reg[VAL_W-1:0];
            sum_sat   = 1'b0;
        end
        else if (acc_reg[ACC_W-1])
        begin
            sum_value = {1'b1, {(VAL_W-1){1'b0}}};
            sum_sat   = 1'b1;
        end
        else
        begin
            sum_value = {1'b0, {(VAL_W-1){1'b1}}};
            sum_sat   = 1'b1;
        end
    end

endmodule

>>> design/matrix_multiply_engine.sv
// Matrix multiply engine, Y = A * B in signed Q16.16. Write items store one
// element of A or B; writes outside the configured sizes are dropped. A
// request item for Y(row, col) streams n_inner pairs out of the two element
// memories through a single multiply-accumulate unit: one pair is issued per
// cycle, followed by the memory read stage, the product register and the
// accumulate. The engine takes no further item until the result has been
// handed to the output register and it is back in idle. A request with row
// or column out of range answers in the next cycle with status set.
// A finished result waits in the output register; writes are still taken
// meanwhile, while a further request waits until that slot is free.
// Products are floored to Q16.16, summed at full width and saturated to
// 32 bits with the saturated flag. Configure m_rows, n_inner and o_cols only
// while the engine is idle; values above MAX_DIM act as MAX_DIM.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              cmd,
    input  logic [3:0]              row,
    input  logic [3:0]              col,
    input  logic signed [VAL_W-1:0] value,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] result_value,
    output logic                    saturated,
    output logic                    status
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(MAX_DIM + 1);
    localparam int KW    = $clog2(MAX_DIM);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] m_rows_reg, n_inner_reg, o_cols_reg;
    logic [EW-1:0]    m_eff, n_eff, o_eff;

    logic [3:0]       row_reg, col_reg;
    logic [KW-1:0]    k_reg;
    logic             v1_reg, v2_reg;

    logic             out_valid_reg;
    logic signed [VAL_W-1:0] result_value_reg;
    logic             saturated_reg, status_reg;

    logic             slot_free, accept, is_req;
    logic             a_wr_ok, b_wr_ok, req_in_range, last_issue;
    logic             issue, req_start, load_err, load_ok;
    logic             a_wr_en, b_wr_en;
    logic [AW-1:0]    wr_addr, a_rd_addr, b_rd_addr;
    logic [VAL_W-1:0] a_rd_data, b_rd_data;
    mac_ctrl_t        mac_ctrl;
    logic signed [VAL_W-1:0] sum_value;
    logic             sum_sat;

    assign m_eff = (32'(m_rows_reg) > MAX_DIM) ? EW'(MAX_DIM) : EW'(m_rows_reg);
    assign n_eff = (32'(n_inner_reg) > MAX_DIM) ? EW'(MAX_DIM) : EW'(n_inner_reg);
    assign o_eff = (32'(o_cols_reg) > MAX_DIM) ? EW'(MAX_DIM) : EW'(o_cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_rows_reg  <= DIM_RESET;
            n_inner_reg <= DIM_RESET;
            o_cols_reg  <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_M_ROWS:  m_rows_reg  <= cfg_data;
                REG_N_INNER: n_inner_reg <= cfg_data;
                REG_O_COLS:  o_cols_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign a_wr_ok      = (32'(row) < 32'(m_eff)) && (32'(col) < 32'(n_eff));
    assign b_wr_ok      = (32'(row) < 32'(n_eff)) && (32'(col) < 32'(o_eff));
    assign req_in_range = (32'(row) < 32'(m_eff)) && (32'(col) < 32'(o_eff));
    assign last_issue   = (32'(k_reg) == 32'(n_eff) - 32'd1);
    assign is_req       = (cmd == CMD_REQUEST);

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && (!is_req || slot_free);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_req && req_in_range)
                begin
                    state_next = (n_eff == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        issue     = 1'b0;
        req_start = 1'b0;
        load_err  = 1'b0;
        load_ok   = 1'b0;
        a_wr_en   = 1'b0;
        b_wr_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                a_wr_en   = accept && (cmd == CMD_WRITE_A) && a_wr_ok;
                b_wr_en   = accept && (cmd == CMD_WRITE_B) && b_wr_ok;
                req_start = accept && is_req && req_in_range;
                load_err  = accept && is_req && !req_in_range;
            end
            ST_RUN:    issue   = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: load_ok = slot_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (req_start)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + KW'(1);
            end
            if (load_err || load_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_start)
        begin
            row_reg <= row;
            col_reg <= col;
        end
        if (load_err)
        begin
            result_value_reg <= '0;
            saturated_reg    <= 1'b0;
            status_reg       <= STATUS_ERR;
        end
        else if (load_ok)
        begin
            result_value_reg <= sum_value;
            saturated_reg    <= sum_sat;
            status_reg       <= STATUS_OK;
        end
    end

    // Elements sit row-major, MAX_DIM words to a row.
    assign wr_addr   = AW'(32'(row) * MAX_DIM + 32'(col));
    assign a_rd_addr = AW'(32'(row_reg) * MAX_DIM + 32'(k_reg));
    assign b_rd_addr = AW'(32'(k_reg) * MAX_DIM + 32'(col_reg));

    mme_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (issue),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mme_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (issue),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    assign mac_ctrl.clear  = req_start;
    assign mac_ctrl.mul_en = v1_reg;
    assign mac_ctrl.acc_en = v2_reg;

    mme_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk       (clk),
        .ctrl      (mac_ctrl),
        .a_data    ($signed(a_rd_data)),
        .b_data    ($signed(b_rd_data)),
        .sum_value (sum_value),
        .sum_sat   (sum_sat)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign saturated    = saturated_reg;
    assign status       = status_reg;

endmodule

>>> verif/mme_result_checker.sv
`timescale 1ns / 100ps

module mme_result_checker
    import mme_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [1:0]              cmd,
    input  logic [3:0]              row,
    input  logic [3:0]              col,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [VAL_W-1:0] result_value,
    input  logic                    saturated,
    input  logic                    status,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    sat;
        logic                    status;
    } y_elem_t;

    localparam longint Y_MAX = 64'sd2147483647;
    localparam longint Y_MIN = -64'sd2147483648;

    logic signed [VAL_W-1:0] a_mem [MAX_DIM_DEF][MAX_DIM_DEF];
    logic signed [VAL_W-1:0] b_mem [MAX_DIM_DEF][MAX_DIM_DEF];
    logic [CFG_W-1:0]        m_rows;
    logic [CFG_W-1:0]        n_inner;
    logic [CFG_W-1:0]        o_cols;
    y_elem_t                 y_expected [$];
    int                      err_count = 0;

    assign mismatches = err_count;

    // Register values above the store size behave as the full size.
    function automatic int clamp_dim(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
    endfunction

    function automatic y_elem_t predict_element(input logic [3:0] r, input logic [3:0] c);
        y_elem_t res;
        longint  acc;
        longint  prod;
        int      k;
        res = '0;
        if (r >= clamp_dim(m_rows) || c >= clamp_dim(o_cols))
        begin
            res.status = STATUS_ERR;
            return res;
        end
        acc = 0;
        for (k = 0; k < clamp_dim(n_inner); k++)
        begin
            prod = longint'(a_mem[r][k]) * longint'(b_mem[k][c]);
            // Arithmetic shift of a signed product floors toward minus infinity.
            acc += prod >>> FRAC_W;
        end
        if (acc > Y_MAX)
        begin
            acc = Y_MAX;
            res.sat = 1'b1;
        end
        else if (acc < Y_MIN)
        begin
            acc = Y_MIN;
            res.sat = 1'b1;
        end
        res.value = acc[VAL_W-1:0];
        res.status = STATUS_OK;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        err_count++;
    endtask

    task automatic accept_item(input logic [1:0] op, input logic [3:0] r_idx,
                               input logic [3:0] c_idx, input logic signed [VAL_W-1:0] v);
        case (op)
            CMD_WRITE_A:
                if (r_idx < clamp_dim(m_rows) && c_idx < clamp_dim(n_inner))
                    a_mem[r_idx][c_idx] = v;
            CMD_WRITE_B:
                if (r_idx < clamp_dim(n_inner) && c_idx < clamp_dim(o_cols))
                    b_mem[r_idx][c_idx] = v;
            CMD_REQUEST:
                y_expected.push_back(predict_element(r_idx, c_idx));
            default:
                ;
        endcase
    endtask

    task automatic check_result();
        y_elem_t want;
        if (y_expected.size() == 0)
        begin
            flag_mismatch($sformatf("result %0d arrived with no request waiting",
                                    result_value));
            return;
        end
        want = y_expected.pop_front();
        if (result_value !== want.value)
            flag_mismatch($sformatf("result_value %0d, expected %0d",
                                    result_value, want.value));
        if (saturated !== want.sat)
            flag_mismatch($sformatf("saturated %b, expected %b", saturated, want.sat));
        if (status !== want.status)
            flag_mismatch($sformatf("status %b, expected %b", status, want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_rows <= DIM_RESET;
            n_inner <= DIM_RESET;
            o_cols <= DIM_RESET;
            y_expected.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_M_ROWS:  m_rows <= cfg_data;
                    REG_N_INNER: n_inner <= cfg_data;
                    REG_O_COLS:  o_cols <= cfg_data;
                    default:     ;
                endcase
            end
            if (in_valid && in_ready)
                accept_item(cmd, row, col, value);
            if (out_valid && out_ready)
                check_result();
            outstanding <= y_expected.size();
        end
    end

endmodule

>>> verif/tb_matrix_multiply_engine.sv
`timescale 1ns / 100ps

module tb_matrix_multiply_engine;
    import mme_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         ITEM_TARGET   = 1450;
    localparam int         SETTLE_CYCLES = 30;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [1:0]              cfg_index = REG_M_ROWS;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              cmd = CMD_WRITE_A;
    logic [3:0]              row = '0;
    logic [3:0]              col = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [VAL_W-1:0] result_value;
    logic                    saturated;
    logic                    status;
    int                      mismatches;
    int                      outstanding;

    // Which store entries hold a value, so requests never read an unwritten one.
    bit a_known [MAX_DIM_DEF][MAX_DIM_DEF];
    bit b_known [MAX_DIM_DEF][MAX_DIM_DEF];
    int dim_m = MAX_DIM_DEF;
    int dim_n = MAX_DIM_DEF;
    int dim_o = MAX_DIM_DEF;
    int items_sent = 0;
    int send_idle_pct = 21;
    int recv_stall_pct = 83;

    matrix_multiply_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .saturated    (saturated),
        .status       (status)
    );

    mme_result_checker y_check (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] rand_q16();
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range(262143)) - 131072;
            2:
            begin
                case ($urandom_range(5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    4: return 32'sh0001_0000;
                    default: return 32'shFFFF_0000;
                endcase
            end
            default: return int'($urandom_range(2097151)) - 1048576;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                             input logic signed [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        row <= r;
        col <= c;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (op)
            CMD_WRITE_A:
                if (r < dim_m && c < dim_n)
                    a_known[r][c] = 1'b1;
            CMD_WRITE_B:
                if (r < dim_n && c < dim_o)
                    b_known[r][c] = 1'b1;
            default:
                ;
        endcase
        items_sent++;
        // Sender idles lightly while the receiver stalls hard, then the reverse,
        // then both run flat out.
        if (items_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 21;
            recv_stall_pct = 83;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 83;
            recv_stall_pct = 21;
        end
        else
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
    endtask

    task automatic drain_engine();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                            input logic [CFG_W-1:0] o);
        drain_engine();
        cfg_write <= 1'b1;
        cfg_index <= REG_M_ROWS;
        cfg_data <= m;
        @(posedge clk);
        cfg_index <= REG_N_INNER;
        cfg_data <= n;
        @(posedge clk);
        cfg_index <= REG_O_COLS;
        cfg_data <= o;
        @(posedge clk);
        cfg_write <= 1'b0;
        dim_m = (m > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(m);
        dim_n = (n > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(n);
        dim_o = (o > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(o);
    endtask

    // An in-range request first writes whatever part of its row and column is missing.
    task automatic request_element(input logic [3:0] r, input logic [3:0] c);
        int k;
        if (r < dim_m && c < dim_o)
        begin
            for (k = 0; k < dim_n; k++)
            begin
                if (!a_known[r][k])
                    send_item(CMD_WRITE_A, r, k[3:0], rand_q16());
                if (!b_known[k][c])
                    send_item(CMD_WRITE_B, k[3:0], c, rand_q16());
            end
        end
        send_item(CMD_REQUEST, r, c, $urandom);
    endtask

    task automatic random_step();
        int         pick;
        logic [3:0] r;
        logic [3:0] c;
        pick = $urandom_range(99);
        r = 4'($urandom_range(15));
        c = 4'($urandom_range(15));
        if (pick < 30)
        begin
            if (dim_m > 0 && dim_n > 0 && $urandom_range(9) < 8)
            begin
                r = 4'($urandom_range(dim_m - 1));
                c = 4'($urandom_range(dim_n - 1));
            end
            send_item(CMD_WRITE_A, r, c, rand_q16());
        end
        else if (pick < 60)
        begin
            if (dim_n > 0 && dim_o > 0 && $urandom_range(9) < 8)
            begin
                r = 4'($urandom_range(dim_n - 1));
                c = 4'($urandom_range(dim_o - 1));
            end
            send_item(CMD_WRITE_B, r, c, rand_q16());
        end
        else if (pick < 88 && dim_m > 0 && dim_o > 0)
        begin
            r = 4'($urandom_range(dim_m - 1));
            c = 4'($urandom_range(dim_o - 1));
            request_element(r, c);
        end
        else if (pick < 97)
        begin
            // Aim outside the configured size when the size leaves room for it.
            if (dim_m < MAX_DIM_DEF)
                r = 4'($urandom_range(MAX_DIM_DEF - 1, dim_m));
            else if (dim_o < MAX_DIM_DEF)
                c = 4'($urandom_range(MAX_DIM_DEF - 1, dim_o));
            request_element(r, c);
        end
        else
        begin
            send_item(CMD_UNUSED, r, c, $urandom);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                             input logic [CFG_W-1:0] o, input int budget);
        int target;
        set_dims(m, n, o);
        target = items_sent + budget;
        while (items_sent < target)
            random_step();
    endtask

    initial
    begin
        int p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_dims(5'd2, 5'd2, 5'd2);
        send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'sh7FFF_FFFF);
        send_item(CMD_WRITE_A, 4'd0, 4'd1, 32'sh7FFF_FFFF);
        send_item(CMD_WRITE_B, 4'd0, 4'd0, 32'sh7FFF_FFFF);
        send_item(CMD_WRITE_B, 4'd1, 4'd0, 32'sh7FFF_FFFF);
        send_item(CMD_REQUEST, 4'd0, 4'd0, '0);
        send_item(CMD_WRITE_A, 4'd1, 4'd0, 32'sh8000_0000);
        send_item(CMD_WRITE_A, 4'd1, 4'd1, 32'sh8000_0000);
        send_item(CMD_REQUEST, 4'd1, 4'd0, '0);
        // Mixed signs exercise flooring of negative products.
        send_item(CMD_WRITE_B, 4'd0, 4'd1, -32'sd1);
        send_item(CMD_WRITE_B, 4'd1, 4'd1, 32'sh0000_0001);
        send_item(CMD_REQUEST, 4'd0, 4'd1, '0);
        send_item(CMD_REQUEST, 4'd1, 4'd1, '0);
        send_item(CMD_WRITE_A, 4'd15, 4'd15, 32'sh1234_5678);
        send_item(CMD_WRITE_B, 4'd2, 4'd0, 32'sh1234_5678);
        send_item(CMD_UNUSED, 4'd15, 4'd15, 32'shFFFF_FFFF);
        send_item(CMD_REQUEST, 4'd15, 4'd15, 32'shFFFF_FFFF);
        send_item(CMD_REQUEST, 4'd0, 4'd2, '0);

        // An empty dot product gives zero; zero rows turn every request into an error.
        set_dims(5'd2, 5'd0, 5'd2);
        send_item(CMD_REQUEST, 4'd1, 4'd1, '0);
        set_dims(5'd0, 5'd2, 5'd2);
        send_item(CMD_REQUEST, 4'd0, 4'd0, '0);

        // Oversized registers act as the full size, reaching the last row and column.
        set_dims(5'd31, 5'd1, 5'd31);
        send_item(CMD_WRITE_A, 4'd15, 4'd0, 32'sh0001_0000);
        send_item(CMD_WRITE_B, 4'd0, 4'd15, 32'sh8000_0000);
        send_item(CMD_REQUEST, 4'd15, 4'd15, '0);

        run_phase(5'd16, 5'd16, 5'd16, 250);
        run_phase(5'd1, 5'd1, 5'd1, 80);
        run_phase(5'd16, 5'd1, 5'd16, 120);
        run_phase(5'd1, 5'd16, 5'd1, 100);
        run_phase(5'd31, 5'd17, 5'd20, 120);
        run_phase(5'd0, 5'd4, 5'd3, 60);
        run_phase(5'd3, 5'd0, 5'd3, 80);
        run_phase(5'd5, 5'd4, 5'd0, 50);
        for (p = 0; p < 6; p++)
            run_phase(CFG_W'($urandom_range(16, 1)), CFG_W'($urandom_range(16, 1)),
                      CFG_W'($urandom_range(16, 1)), 100);

        drain_engine();
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
